// ----- hdl/pcgbd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_pkg - shared types and constants
// PCG-XSH-RR constants, the command record passed front to back, and the
// output permutation.
// ----------------------------------------------------------------------------
package pcgbd_pkg;

   localparam logic [63:0] LCG_MUL       = 64'h5851_F42D_4C95_7F2D;
   localparam logic [63:0] LCG_INC       = 64'h1405_7B7E_F767_814F;
   localparam logic [63:0] DEFAULT_STATE = 64'h853C_49E6_748F_EA9B;
   localparam logic [31:0] DEFAULT_SEED  = 32'd521288629;

   localparam int XS_SHIFT  = 18;
   localparam int OUT_SHIFT = 27;
   localparam int ROT_SHIFT = 59;

   localparam logic [2:0] ACT_RAW     = 3'd0;
   localparam logic [2:0] ACT_MOD     = 3'd1;
   localparam logic [2:0] ACT_RANGE   = 3'd2;
   localparam logic [2:0] ACT_RESEED  = 3'd3;
   localparam logic [2:0] ACT_DEFAULT = 3'd4;

   typedef enum logic [2:0] {
      CMD_RAW,
      CMD_MOD,
      CMD_RANGE,
      CMD_EMPTY,
      CMD_RESEED,
      CMD_DEFAULT,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  limit;   // modulus, or span for a range draw
      logic [31:0]  low;
      logic [31:0]  seed;
   } cmd_type;

   // XSH-RR output from the pre-step state
   function automatic logic [31:0] pcg_output(input logic [63:0] s);
      logic [63:0] mixed;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] dbl;
      mixed = ((s >> XS_SHIFT) ^ s) >> OUT_SHIFT;
      xs    = mixed[31:0];
      rot   = s[ROT_SHIFT +: 5];
      dbl   = {xs, xs} >> rot;
      return dbl[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- hdl/pcgbd_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_req_if - request channel
// Valid/ready channel carrying one draw or control request.
// ----------------------------------------------------------------------------
interface pcgbd_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] limit;
   logic signed [31:0] range_low;
   logic signed [31:0] range_high;
   logic        exclusive;
   logic [31:0] seed;

   modport source (output valid, action, limit, range_low, range_high, exclusive, seed,
                   input ready);
   modport sink   (input valid, action, limit, range_low, range_high, exclusive, seed,
                   output ready);
endinterface
`default_nettype wire

// ----- hdl/pcgbd_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_rsp_if - response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface pcgbd_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [32:0] value;
   logic        empty_res;

   modport source (output valid, value, empty_res, input ready);
   modport sink   (input valid, value, empty_res, output ready);
endinterface
`default_nettype wire

// ----- hdl/pcgbd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_front - request intake
// Classifies each request, works out the range span and queues the command.
// ----------------------------------------------------------------------------
module pcgbd_front import pcgbd_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   pcgbd_req_if.sink   req_chan,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  wire logic   cmd_pop
);

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cls;
   logic [33:0] span;
   logic        push;

   always_comb begin
      span = {{2{req_chan.range_high[31]}}, req_chan.range_high}
           - {{2{req_chan.range_low[31]}}, req_chan.range_low}
           + {33'd0, ~req_chan.exclusive};
      cls.limit = req_chan.limit;
      cls.low   = req_chan.range_low;
      cls.seed  = req_chan.seed;
      case (req_chan.action)
         ACT_RAW:     cls.kind = CMD_RAW;
         ACT_MOD:     cls.kind = (req_chan.limit == 32'd0) ? CMD_RAW : CMD_MOD;
         ACT_RANGE: begin
            // negative, zero or above 2^32-1
            if (span[33] || span[32] || span[31:0] == 32'd0) begin
               cls.kind = CMD_EMPTY;
            end else begin
               cls.kind  = CMD_RANGE;
               cls.limit = span[31:0];
            end
         end
         ACT_RESEED:  cls.kind = CMD_RESEED;
         ACT_DEFAULT: cls.kind = CMD_DEFAULT;
         default:     cls.kind = CMD_NOP;
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (count_ff != 2'd0);
   assign cmd            = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/pcgbd_divmod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_divmod - 32-bit remainder unit
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcgbd_divmod (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      rem
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[31]};
      diff    = {1'b0, trial} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 32'd0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = diff[33] ? trial[31:0] : diff[31:0];
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

// ----- hdl/pcgbd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcgbd_back - generator core
// Holds the LCG state, steps it with a shared 32x32 multiplier, runs
// rejection and remainder, reseeds, and registers the response.
// ----------------------------------------------------------------------------
module pcgbd_back import pcgbd_pkg::*; #(
   parameter int RESEED_ROUNDS = 10
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cmd_type  cmd,
   input  wire logic     cmd_valid,
   output logic          cmd_pop,
   pcgbd_rsp_if.source   rsp_chan
);

   localparam int RW = $clog2(RESEED_ROUNDS + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_THRESH = 5'b00010,
      S_DRAW   = 5'b00100,
      S_CHECK  = 5'b01000,
      S_MOD    = 5'b10000
   } state_type;

   state_type   fsm_ff, fsm_in;
   cmd_type     cur_ff, cur_in;
   logic [63:0] lcg_ff, lcg_in;
   logic [31:0] seed_ff, seed_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] thr_ff, thr_in;
   logic        first_ff, first_in;
   logic [RW-1:0] rounds_ff, rounds_in;
   logic        out_valid_ff, out_valid_in;
   logic [32:0] value_ff, value_in;
   logic        empty_ff, empty_in;
   logic [31:0] mul_a, mul_b;
   logic        div_start, div_done;
   logic [31:0] div_dividend, div_divisor, div_rem;

   pcgbd_divmod u_divmod (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_comb begin
      case (phase_ff)
         2'd0:    begin mul_a = lcg_ff[31:0];  mul_b = LCG_MUL[31:0];  end
         2'd1:    begin mul_a = lcg_ff[31:0];  mul_b = LCG_MUL[63:32]; end
         default: begin mul_a = lcg_ff[63:32]; mul_b = LCG_MUL[31:0];  end
      endcase
   end

   always_comb begin
      fsm_in       = fsm_ff;
      cur_in       = cur_ff;
      lcg_in       = lcg_ff;
      seed_in      = seed_ff;
      phase_in     = phase_ff;
      prod_in      = {32'd0, mul_a} * {32'd0, mul_b};
      acc_in       = acc_ff;
      word_in      = word_ff;
      thr_in       = thr_ff;
      first_in     = first_ff;
      rounds_in    = rounds_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      value_in     = value_ff;
      empty_in     = empty_ff;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      div_dividend = word_ff;
      div_divisor  = cur_ff.limit;

      case (fsm_ff)
         S_IDLE: begin
            if (cmd_valid && !out_valid_ff) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               phase_in = 2'd0;
               case (cmd.kind)
                  CMD_RAW, CMD_MOD: fsm_in = S_DRAW;
                  CMD_RANGE: begin
                     // threshold = (2^32 - span) mod span
                     div_start    = 1'b1;
                     div_dividend = 32'd0 - cmd.limit;
                     div_divisor  = cmd.limit;
                     fsm_in       = S_THRESH;
                  end
                  CMD_EMPTY: begin
                     out_valid_in = 1'b1;
                     value_in     = 33'd0;
                     empty_in     = 1'b1;
                  end
                  CMD_RESEED: begin
                     lcg_in    = 64'd0;
                     first_in  = 1'b1;
                     rounds_in = '0;
                     fsm_in    = S_DRAW;
                  end
                  CMD_DEFAULT: begin
                     lcg_in       = DEFAULT_STATE;
                     seed_in      = DEFAULT_SEED;
                     out_valid_in = 1'b1;
                     value_in     = 33'd0;
                     empty_in     = 1'b0;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                     value_in     = 33'd0;
                     empty_in     = 1'b0;
                  end
               endcase
            end
         end

         S_THRESH: begin
            if (div_done) begin
               thr_in   = div_rem;
               phase_in = 2'd0;
               fsm_in   = S_DRAW;
            end
         end

         S_DRAW: begin
            phase_in = phase_ff + 2'd1;
            case (phase_ff)
               2'd1: acc_in = prod_ff;
               2'd2: acc_in[63:32] = acc_ff[63:32] + prod_ff[31:0];
               2'd3: begin
                  word_in = pcg_output(lcg_ff);
                  lcg_in  = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]} + LCG_INC;
                  fsm_in  = S_CHECK;
               end
               default: ;
            endcase
         end

         S_CHECK: begin
            phase_in = 2'd0;
            case (cur_ff.kind)
               CMD_MOD: begin
                  div_start = 1'b1;
                  fsm_in    = S_MOD;
               end
               CMD_RANGE: begin
                  if (word_ff < thr_ff) begin
                     fsm_in = S_DRAW;   // rejected, draw again
                  end else begin
                     div_start = 1'b1;
                     fsm_in    = S_MOD;
                  end
               end
               CMD_RESEED: begin
                  if (first_ff) begin
                     lcg_in   = lcg_ff + {32'd0, cur_ff.seed};
                     first_in = 1'b0;
                     fsm_in   = S_DRAW;
                  end else if (rounds_ff == RW'(RESEED_ROUNDS - 1)) begin
                     seed_in      = cur_ff.seed;
                     out_valid_in = 1'b1;
                     value_in     = {1'b0, seed_ff};
                     empty_in     = 1'b0;
                     fsm_in       = S_IDLE;
                  end else begin
                     rounds_in = rounds_ff + RW'(1);
                     fsm_in    = S_DRAW;
                  end
               end
               default: begin
                  out_valid_in = 1'b1;
                  value_in     = {1'b0, word_ff};
                  empty_in     = 1'b0;
                  fsm_in       = S_IDLE;
               end
            endcase
         end

         S_MOD: begin
            if (div_done) begin
               out_valid_in = 1'b1;
               empty_in     = 1'b0;
               if (cur_ff.kind == CMD_RANGE) begin
                  value_in = {cur_ff.low[31], cur_ff.low} + {1'b0, div_rem};
               end else begin
                  value_in = {1'b0, div_rem};
               end
               fsm_in = S_IDLE;
            end
         end

         default: fsm_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         lcg_ff       <= DEFAULT_STATE;
         seed_ff      <= DEFAULT_SEED;
         phase_ff     <= 2'd0;
         first_ff     <= 1'b0;
         rounds_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         lcg_ff       <= lcg_in;
         seed_ff      <= seed_in;
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         rounds_ff    <= rounds_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      word_ff  <= word_in;
      thr_ff   <= thr_in;
      value_ff <= value_in;
      empty_ff <= empty_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.value     = value_ff;
   assign rsp_chan.empty_res = empty_ff;

endmodule
`default_nettype wire

// ----- hdl/pcg32_generator_bounded_draw.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pcg32_generator_bounded_draw - PCG32 (XSH-RR) with bounded draws
// One response per request on valid/ready channels req_chan and rsp_chan.
// Actions: raw word (also the Q0.32 fraction), word mod limit, unbiased
// range draw by rejection, reseed (returns the previous seed), default.
// Each draw takes an LCG step on the shared 32x32 multiplier, then a check;
// modulo and range draws then run the 1-bit/cycle divider for the remainder,
// range draws first run it for the threshold and redraw each rejected word;
// reseed runs RESEED_ROUNDS+1 LCG steps; default, empty range and nop answer
// straight from idle.
// Requests are served one at a time; a two-deep queue keeps taking requests
// while one is in work or a response waits.
// Reset: state 0x853c49e6748fea9b, seed 521288629, queue and response empty.
// A stalled receiver holds the response register; the core then stops after
// its current request and the queue fills, dropping req_chan.ready.
// ----------------------------------------------------------------------------
module pcg32_generator_bounded_draw import pcgbd_pkg::*; #(
   parameter int RESEED_ROUNDS = 10
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pcgbd_req_if.sink   req_chan,
   pcgbd_rsp_if.source rsp_chan
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // intake: classify, span, queue
   pcgbd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // core: LCG step, rejection, remainder, response register
   pcgbd_back #(
      .RESEED_ROUNDS (RESEED_ROUNDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
`default_nettype wire
